// File: rtl/core/lqr_pkg.sv
// shared types, widths and codes for the lqr state-feedback core
`timescale 1ns / 1ps

package lqr_pkg;

  localparam int DEF_NUM_STATES  = 8;
  localparam int DEF_NUM_OUTPUTS = 4;
  localparam int MAX_EMIT        = 4;

  localparam int KIND_W     = 2;
  localparam int ROW_W      = 2;
  localparam int COLUMN_W   = 3;
  localparam int COEF_W     = 20;
  localparam int SIG_W      = 16;
  localparam int ERR_W      = SIG_W + 1;
  localparam int GAIN_W     = 20;
  localparam int PROD_W     = ERR_W + GAIN_W;
  localparam int ACC_W      = 40;
  localparam int DRIVE_W    = 16;
  localparam int FRAC_SHIFT = 14;
  localparam int U_W        = ACC_W + 1 - FRAC_SHIFT;
  localparam int D_W        = U_W + 1;
  localparam int ACT_W      = 2;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [KIND_W-1:0] KIND_GAIN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EQ     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

  localparam logic signed [ACC_W:0] ROUND_HALF = (ACC_W + 1)'(8192);

  typedef struct packed {
    logic [KIND_W-1:0]        op;
    logic [ROW_W-1:0]         row;
    logic [COLUMN_W-1:0]      col;
    logic                     col_ok;
    logic                     fin;
    logic signed [COEF_W-1:0] data;
  } lqr_cmd_t;

endpackage

// File: rtl/core/lqr_state_feedback_core.sv
// top level of the lqr state-feedback core
`timescale 1ns / 1ps

// State-feedback regulator: load beats fill the gain table and equilibrium drives,
// sample beats accumulate gain * (measured - setpoint) for every output, and a sample
// with tlast set produces one drive beat per output (at most four), ending with tlast.
// Load beats are carried out at one per cycle; a sample beat reads the single port of
// the gain ram once per output. Accepted beats wait in a four-entry queue. Drives of a
// finished run leave from a snapshot bank at one per cycle while the output is ready,
// and later samples keep accumulating meanwhile; a further final sample waits until the
// previous run's last drive has entered the output register. The first drive passes
// through the multiply, accumulate and snapshot registers before the output register.
module lqr_state_feedback_core #(
  parameter int NUM_STATES  = lqr_pkg::DEF_NUM_STATES,
  parameter int NUM_OUTPUTS = lqr_pkg::DEF_NUM_OUTPUTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // row[1:0], column[4:2], coefficient[24:5], measured[40:25], setpoint[56:41]
  input  logic [lqr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [lqr_pkg::KIND_W-1:0]      in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // drive[15:0], clipped[16]
  output logic [lqr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // actuator[1:0]
  output logic [lqr_pkg::ACT_W-1:0]       out_tuser,
  output logic                            out_tlast
);
  import lqr_pkg::*;

  logic     cmd_valid;
  logic     cmd_pop;
  lqr_cmd_t cmd;

  lqr_front #(
    .NUM_STATES  (NUM_STATES),
    .NUM_OUTPUTS (NUM_OUTPUTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  lqr_back #(
    .NUM_STATES  (NUM_STATES),
    .NUM_OUTPUTS (NUM_OUTPUTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/core/lqr_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps

module lqr_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/lqr_front.sv
// front end: accepts input beats, classifies them and queues commands
`timescale 1ns / 1ps

module lqr_front #(
  parameter int NUM_STATES  = lqr_pkg::DEF_NUM_STATES,
  parameter int NUM_OUTPUTS = lqr_pkg::DEF_NUM_OUTPUTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lqr_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [lqr_pkg::KIND_W-1:0]      in_tuser,
  input  logic                            in_tlast,
  output logic                            cmd_valid,
  output lqr_pkg::lqr_cmd_t               cmd,
  input  logic                            cmd_pop
);
  import lqr_pkg::*;

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  logic [ROW_W-1:0]         row;
  logic [COLUMN_W-1:0]      col;
  logic signed [COEF_W-1:0] coef;
  logic signed [SIG_W-1:0]  meas;
  logic signed [SIG_W-1:0]  setp;
  logic signed [ERR_W-1:0]  err;
  logic signed [SIG_W-1:0]  eq_sat;
  logic                     row_ok;
  logic                     col_ok;
  logic                     keep;
  logic                     push;
  lqr_cmd_t                 entry;

  lqr_cmd_t            q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign row  = in_tdata[1:0];
  assign col  = in_tdata[4:2];
  assign coef = in_tdata[24:5];
  assign meas = in_tdata[40:25];
  assign setp = in_tdata[56:41];

  assign err    = {meas[SIG_W-1], meas} - {setp[SIG_W-1], setp};
  assign row_ok = int'(row) < NUM_OUTPUTS;
  assign col_ok = int'(col) < NUM_STATES;

  always_comb begin
    if (coef > COEF_W'(32767)) begin
      eq_sat = 16'sh7fff;
    end else if (coef < -COEF_W'(32768)) begin
      eq_sat = -16'sh8000;
    end else begin
      eq_sat = coef[SIG_W-1:0];
    end
  end

  always_comb begin
    case (in_tuser)
      KIND_GAIN:   keep = row_ok && col_ok;
      KIND_EQ:     keep = row_ok;
      KIND_SAMPLE: keep = 1'b1;
      default:     keep = 1'b0;
    endcase
  end

  always_comb begin
    entry.op     = in_tuser;
    entry.row    = row;
    entry.col    = col;
    entry.col_ok = col_ok;
    entry.fin    = in_tlast;
    case (in_tuser)
      KIND_GAIN:   entry.data = coef;
      KIND_EQ:     entry.data = {{(COEF_W-SIG_W){eq_sat[SIG_W-1]}}, eq_sat};
      default:     entry.data = {{(COEF_W-ERR_W){err[ERR_W-1]}}, err};
    endcase
  end

  assign in_tready = count_r != (QPTR_W+1)'(QUEUE_DEPTH);
  assign push      = in_tvalid && in_tready && keep;
  assign cmd_valid = count_r != '0;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !cmd_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// File: rtl/core/lqr_back.sv
// back end: gain table, multiply-accumulate pipeline, drive snapshot and output register
`timescale 1ns / 1ps

module lqr_back #(
  parameter int NUM_STATES  = lqr_pkg::DEF_NUM_STATES,
  parameter int NUM_OUTPUTS = lqr_pkg::DEF_NUM_OUTPUTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  input  lqr_pkg::lqr_cmd_t               cmd,
  output logic                            cmd_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lqr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [lqr_pkg::ACT_W-1:0]       out_tuser,
  output logic                            out_tlast
);
  import lqr_pkg::*;

  localparam int GAIN_DEPTH = NUM_OUTPUTS * NUM_STATES;
  localparam int ADDR_W     = $clog2(GAIN_DEPTH > 1 ? GAIN_DEPTH : 2);
  localparam int OUT_W      = $clog2(NUM_OUTPUTS > 1 ? NUM_OUTPUTS : 2);
  localparam int NUM_EMIT   = NUM_OUTPUTS < MAX_EMIT ? NUM_OUTPUTS : MAX_EMIT;
  localparam int EMIT_W     = $clog2(NUM_EMIT > 1 ? NUM_EMIT : 2);

  // issue stage
  lqr_cmd_t         cur_r;
  logic             cur_valid_r;
  logic [OUT_W-1:0] cnt_r;
  logic             final_pend_r;
  logic             is_sample;
  logic             last_o;
  logic             stall;
  logic             act;
  logic             cur_done;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [GAIN_W-1:0] ram_rdata;

  logic signed [SIG_W-1:0] eq_r [NUM_OUTPUTS];

  // multiply and accumulate stages
  logic                     s1_valid_r;
  logic [OUT_W-1:0]         s1_o_r;
  logic signed [ERR_W-1:0]  s1_err_r;
  logic                     s1_add_r;
  logic                     s1_snap_r;
  logic                     s2_valid_r;
  logic [OUT_W-1:0]         s2_o_r;
  logic                     s2_snap_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_r;

  logic signed [ACC_W-1:0] acc_r   [NUM_OUTPUTS];
  logic signed [ACC_W-1:0] acc_nxt [NUM_OUTPUTS];
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] sum_sat;

  // snapshot and emission
  logic signed [ACC_W-1:0] snap_acc_r [NUM_EMIT];
  logic signed [SIG_W-1:0] snap_eq_r  [NUM_EMIT];
  logic                    snap_valid_r;
  logic [EMIT_W-1:0]       e_r;
  logic                    emit;
  logic                    last_e;
  logic signed [ACC_W:0]   rsum;
  logic signed [U_W-1:0]   u;
  logic signed [D_W-1:0]   d;
  logic                    clip;
  logic [DRIVE_W-1:0]      drive;

  logic                    out_valid_r;
  logic [DRIVE_W-1:0]      out_drive_r;
  logic                    out_clip_r;
  logic                    out_last_r;
  logic [ACT_W-1:0]        out_act_r;

  assign is_sample = cur_r.op == KIND_SAMPLE;
  assign last_o    = cnt_r == OUT_W'(NUM_OUTPUTS - 1);
  assign stall     = cur_valid_r && is_sample && cur_r.fin && (cnt_r == '0) && final_pend_r;
  assign act       = cur_valid_r && !stall;
  assign cur_done  = act && (!is_sample || last_o);
  assign cmd_pop   = cmd_valid && (!cur_valid_r || cur_done);

  assign ram_we = act && (cur_r.op == KIND_GAIN);

  always_comb begin
    if (cur_r.op == KIND_GAIN) begin
      ram_addr = ADDR_W'(int'(cur_r.row) * NUM_STATES + int'(cur_r.col));
    end else if (cur_r.col_ok) begin
      ram_addr = ADDR_W'(int'(cnt_r) * NUM_STATES + int'(cur_r.col));
    end else begin
      ram_addr = '0;
    end
  end

  lqr_ram #(
    .WIDTH (GAIN_W),
    .DEPTH (GAIN_DEPTH)
  ) u_gain_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cur_r.data),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else if (cmd_pop) begin
      cur_valid_r <= 1'b1;
      cnt_r       <= '0;
    end else if (cur_done) begin
      cur_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else if (act && is_sample) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        eq_r[i] <= '0;
      end
    end else if (act && (cur_r.op == KIND_EQ)) begin
      eq_r[OUT_W'(cur_r.row)] <= cur_r.data[SIG_W-1:0];
    end
  end

  // equilibrium drives are frozen with the last read of a final sample
  always_ff @(posedge clk) begin
    if (act && is_sample && cur_r.fin && last_o) begin
      for (int i = 0; i < NUM_EMIT; i++) begin
        snap_eq_r[i] <= eq_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= act && is_sample;
      s2_valid_r <= s1_valid_r;
    end
  end

  assign prod = s1_err_r * $signed(ram_rdata);

  always_ff @(posedge clk) begin
    s1_o_r    <= cnt_r;
    s1_err_r  <= cur_r.data[ERR_W-1:0];
    s1_add_r  <= cur_r.col_ok;
    s1_snap_r <= cur_r.fin && last_o;
    s2_o_r    <= s1_o_r;
    s2_snap_r <= s1_snap_r;
    prod_r    <= s1_add_r ? prod : '0;
  end

  assign sum = {acc_r[s2_o_r][ACC_W-1], acc_r[s2_o_r]}
             + {{(ACC_W + 1 - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_OUTPUTS; i++) begin
      acc_nxt[i] = acc_r[i];
      if (s2_valid_r && (s2_o_r == OUT_W'(i))) begin
        acc_nxt[i] = sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        acc_r[i] <= '0;
      end
    end else if (s2_valid_r && s2_snap_r) begin
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && s2_snap_r) begin
      for (int i = 0; i < NUM_EMIT; i++) begin
        snap_acc_r[i] <= acc_nxt[i];
      end
    end
  end

  // drive = equilibrium - round(acc / 2^14), saturated
  assign rsum = {snap_acc_r[e_r][ACC_W-1], snap_acc_r[e_r]} + ROUND_HALF;
  assign u    = rsum[ACC_W:FRAC_SHIFT];
  assign d    = {{(D_W-SIG_W){snap_eq_r[e_r][SIG_W-1]}}, snap_eq_r[e_r]} - {u[U_W-1], u};
  assign clip = !((&d[D_W-1:DRIVE_W-1]) || (~|d[D_W-1:DRIVE_W-1]));

  always_comb begin
    if (clip) begin
      drive = d[D_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
    end else begin
      drive = d[DRIVE_W-1:0];
    end
  end

  assign last_e = e_r == EMIT_W'(NUM_EMIT - 1);
  assign emit   = snap_valid_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
      e_r          <= '0;
      final_pend_r <= 1'b0;
    end else begin
      if (act && is_sample && cur_r.fin && (cnt_r == '0)) begin
        final_pend_r <= 1'b1;
      end
      if (s2_valid_r && s2_snap_r) begin
        snap_valid_r <= 1'b1;
        e_r          <= '0;
      end else if (emit) begin
        if (last_e) begin
          snap_valid_r <= 1'b0;
          final_pend_r <= 1'b0;
          e_r          <= '0;
        end else begin
          e_r <= e_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_drive_r <= drive;
      out_clip_r  <= clip;
      out_last_r  <= last_e;
      out_act_r   <= ACT_W'(e_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - DRIVE_W - 1){1'b0}}, out_clip_r, out_drive_r};
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_last_r;

endmodule
